// ----- hw/rtl/siq_pkg.sv -----
// shared types and constants for the sorted insert queue
`timescale 1ns / 1ps
`default_nettype none

package siq_pkg;

	// number of records the store holds
	localparam int DEPTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths
	localparam int KEY_W  = 48;
	localparam int LEN_W  = 31;
	localparam int FID_W  = 31;
	localparam int FOFF_W = 48;
	localparam int OCC_W  = 6;
	localparam int KIND_W = 2;

	// stream widths
	localparam int S_TDATA_W = 160;
	localparam int M_TDATA_W = 168;
	localparam int M_TUSER_W = 3;

	// command codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  length;
		logic [FID_W-1:0]  file_id;
		logic [FOFF_W-1:0] foff;
	} rec_t;

	typedef struct packed {
		logic op;
		rec_t rec;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              rejected;
		rec_t              rec;
		logic [OCC_W-1:0]  occupancy;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_insert_queue_top.sv -----
// Sorted insert queue top level. Holds up to DEPTH records in ascending key order;
// an insert goes ahead of stored entries with an equal key and is refused when the
// store is full, and a drain returns every entry in order with tlast on the final
// one (an empty store gives a single empty beat). Inputs pass an input register and
// a two-entry command queue before the back end. Inserts are taken one per cycle
// while the output register is free; a drain of n entries gives one result beat
// per cycle while the receiver takes them, from the single output register that
// drives the master side, after the input register and the command queue.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_queue_top import siq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// key_offset, rec_length, rec_file_id, rec_file_offset, zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  wire logic [0:0]           s_tuser,
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_offset, out_length, out_file_id, out_file_offset, occupancy, zero pad
	output logic [M_TDATA_W-1:0]      m_tdata,
	// kind, rejected
	output logic [M_TUSER_W-1:0]      m_tuser,
	output logic                      m_tlast
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;
	res_t res;

	siq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	siq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	siq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result beat
	assign m_tdata = {4'b0, res.occupancy, res.rec.foff, res.rec.file_id,
		res.rec.length, res.rec.key};
	assign m_tuser = {res.rejected, res.kind};
	assign m_tlast = res.last;

endmodule

`default_nettype wire

// ----- hw/rtl/siq_front.sv -----
// front end: input beat register and command classification
`timescale 1ns / 1ps
`default_nettype none

module siq_front import siq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [0:0]           s_tuser,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output cmd_t                      push_cmd
);

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;

	// unpack the beat and tag it as insert or drain
	always_comb begin
		cmd_in.op              = (s_tuser[0] == OP_DRAIN) ? OP_DRAIN : OP_INSERT;
		cmd_in.rec.key         = s_tdata[47:0];
		cmd_in.rec.length      = s_tdata[78:48];
		cmd_in.rec.file_id     = s_tdata[109:79];
		cmd_in.rec.foff        = s_tdata[157:110];
		// a drain carries no record
		if (cmd_in.op == OP_DRAIN) begin
			cmd_in.rec = '0;
		end
	end

	assign s_tready   = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_cmd   = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/siq_cmd_queue.sv -----
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module siq_cmd_queue import siq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  cmd_t      push_cmd,
	output logic      pop_valid,
	input  wire logic pop,
	output cmd_t      pop_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/siq_back.sv -----
// back end: sorted shifting cell store and result register
`timescale 1ns / 1ps
`default_nettype none

module siq_back import siq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	rec_t             cell_q [DEPTH];
	logic [DEPTH-1:0] lt;
	logic [CNT_W-1:0] cnt_q;
	logic             full;
	logic             out_free;
	logic             fire;
	logic             do_insert;
	logic             do_shift_out;
	logic             m_valid_q;
	res_t             res_q;
	res_t             res_d;

	assign full         = (cnt_q == CNT_W'(DEPTH));
	assign out_free     = !m_valid_q || out_ready;
	assign fire         = q_valid && out_free;
	assign do_insert    = fire && (q_cmd.op == OP_INSERT) && !full;
	assign do_shift_out = fire && (q_cmd.op == OP_DRAIN) && (cnt_q != '0);
	assign q_pop        = fire && ((q_cmd.op == OP_INSERT) || (cnt_q <= CNT_W'(1)));

	// per-cell key compare and shift network
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign lt[i] = (CNT_W'(i) < cnt_q) && (cell_q[i].key < q_cmd.rec.key);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (!lt[i]) begin
						cell_q[i] <= q_cmd.rec;
					end
				end else if (do_shift_out) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end else if (i == DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_insert && !lt[i]) begin
					cell_q[i] <= lt[i-1] ? q_cmd.rec : cell_q[i-1];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (!lt[i]) begin
						cell_q[i] <= lt[i-1] ? q_cmd.rec : cell_q[i-1];
					end
				end else if (do_shift_out) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_insert) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (do_shift_out) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// build the result beat
	always_comb begin
		res_d          = '0;
		res_d.last     = 1'b1;
		if (q_cmd.op == OP_INSERT) begin
			res_d.kind      = KIND_ACK;
			res_d.rejected  = full;
			res_d.occupancy = full ? OCC_W'(cnt_q) : OCC_W'(cnt_q + CNT_W'(1));
		end else if (cnt_q == '0) begin
			res_d.kind = KIND_EMPTY;
		end else begin
			res_d.kind      = KIND_ENTRY;
			res_d.rec       = cell_q[0];
			res_d.occupancy = OCC_W'(cnt_q - CNT_W'(1));
			res_d.last      = (cnt_q == CNT_W'(1));
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= fire;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid = m_valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/siq_checker.sv -----
// port-level assertions for the sorted insert queue and their binding
`timescale 1ns / 1ps
`default_nettype none

module siq_checker import siq_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser,
	input wire logic                 m_tlast
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	// acknowledge and empty beats are single and carry no record
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != KIND_ENTRY) |-> m_tlast && (m_tdata[157:0] == '0))
		else $error("non-entry beat carries data or lacks tlast");

	// a refused insert only happens on a full store
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == KIND_ACK)
			&& (m_tdata[163:158] == OCC_W'(DEPTH)))
		else $error("reject without full store");

	// drained entries count down to an empty store at tlast
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_ENTRY) && m_tlast |-> m_tdata[163:158] == '0)
		else $error("drain ended with entries left");

	// drain beats after a taken non-final entry continue the drain
	a_drain_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tuser[1:0] == KIND_ENTRY) && !m_tlast
			|=> !m_tvalid || (m_tuser[1:0] == KIND_ENTRY))
		else $error("drain interrupted");

endmodule

bind sorted_insert_queue_top siq_checker u_siq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ----- verif/siq_checker.sv -----
// result checker for the sorted insert queue: tracks the store and compares every result beat
`timescale 1ns / 1ps

module siq_scoreboard import siq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// key_offset, rec_length, rec_file_id, rec_file_offset, zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  wire logic [0:0]           s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// out_offset, out_length, out_file_id, out_file_offset, occupancy, zero pad
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	// kind, rejected
	input  wire logic [M_TUSER_W-1:0] m_tuser,
	input  wire logic                 m_tlast,
	output int                        errors,
	output int                        pending,
	output int                        beats_checked,
	output int                        refusals,
	output int                        longest_drain
);

	// bit positions of the packed fields
	localparam int LEN_LO  = KEY_W;
	localparam int FID_LO  = LEN_LO + LEN_W;
	localparam int FOFF_LO = FID_LO + FID_W;
	localparam int OCC_LO  = FOFF_LO + FOFF_W;

	rec_t sorted_recs [DEPTH];
	int   held = 0;
	res_t expected_beats [$];
	int   mismatch_count = 0;
	int   checked_count = 0;
	int   refused_count = 0;
	int   longest_count = 0;
	int   open_count = 0;

	assign errors        = mismatch_count;
	assign pending       = open_count;
	assign beats_checked = checked_count;
	assign refusals      = refused_count;
	assign longest_drain = longest_count;

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// work out the beats one command causes and update the tracked store
	task automatic predict_beats(input logic op, input rec_t r);
		res_t b;
		int   pos;
		b = '0;
		b.last = 1'b1;
		if (op == OP_INSERT) begin
			b.kind = KIND_ACK;
			if (held >= DEPTH) begin
				// full store: refused, nothing moves
				b.rejected = 1'b1;
				refused_count++;
			end else begin
				// new record goes ahead of any older entry with the same key
				pos = 0;
				while (pos < held && sorted_recs[pos].key < r.key) pos++;
				for (int i = held; i > pos; i--) sorted_recs[i] = sorted_recs[i-1];
				sorted_recs[pos] = r;
				held++;
			end
			b.occupancy = OCC_W'(held);
			expected_beats.push_back(b);
		end else if (held == 0) begin
			// drain of an empty store gives one empty beat
			b.kind = KIND_EMPTY;
			expected_beats.push_back(b);
		end else begin
			// drain: every entry in order, count going down to zero
			for (int i = 0; i < held; i++) begin
				b.kind      = KIND_ENTRY;
				b.rec       = sorted_recs[i];
				b.occupancy = OCC_W'(held - i - 1);
				b.last      = (i == held - 1);
				expected_beats.push_back(b);
			end
			if (held > longest_count) longest_count = held;
			held = 0;
		end
	endtask

	// compare one result beat with the oldest expectation
	task automatic check_beat();
		res_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("beat with nothing pending", 64'(m_tdata[OCC_LO +: OCC_W]), 64'd0);
		end else begin
			want = expected_beats.pop_front();
			checked_count++;
			if (m_tuser[KIND_W-1:0] !== want.kind)
				report_mismatch("kind", 64'(m_tuser[KIND_W-1:0]), 64'(want.kind));
			if (m_tuser[KIND_W] !== want.rejected)
				report_mismatch("rejected", 64'(m_tuser[KIND_W]), 64'(want.rejected));
			if (m_tdata[KEY_W-1:0] !== want.rec.key)
				report_mismatch("out_offset", 64'(m_tdata[KEY_W-1:0]), 64'(want.rec.key));
			if (m_tdata[LEN_LO +: LEN_W] !== want.rec.length)
				report_mismatch("out_length", 64'(m_tdata[LEN_LO +: LEN_W]),
					64'(want.rec.length));
			if (m_tdata[FID_LO +: FID_W] !== want.rec.file_id)
				report_mismatch("out_file_id", 64'(m_tdata[FID_LO +: FID_W]),
					64'(want.rec.file_id));
			if (m_tdata[FOFF_LO +: FOFF_W] !== want.rec.foff)
				report_mismatch("out_file_offset", 64'(m_tdata[FOFF_LO +: FOFF_W]),
					64'(want.rec.foff));
			if (m_tdata[OCC_LO +: OCC_W] !== want.occupancy)
				report_mismatch("occupancy", 64'(m_tdata[OCC_LO +: OCC_W]),
					64'(want.occupancy));
			if (m_tlast !== want.last)
				report_mismatch("tlast", 64'(m_tlast), 64'(want.last));
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		rec_t r;
		if (!arst_n) begin
			held = 0;
			expected_beats.delete();
			open_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				r.key         = s_tdata[KEY_W-1:0];
				r.length      = s_tdata[LEN_LO +: LEN_W];
				r.file_id     = s_tdata[FID_LO +: FID_W];
				r.foff        = s_tdata[FOFF_LO +: FOFF_W];
				predict_beats(s_tuser[0], r);
			end
			if (m_tvalid && m_tready) check_beat();
			open_count = expected_beats.size();
		end
	end

endmodule

// ----- verif/tb_sorted_insert_queue_top.sv -----
// testbench top for the sorted insert queue: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_sorted_insert_queue_top;
	import siq_pkg::*;

	localparam int LEN_LO      = KEY_W;
	localparam int FID_LO      = LEN_LO + LEN_W;
	localparam int FOFF_LO     = FID_LO + FID_W;
	localparam int RANDOM_CMDS = 90;
	localparam int HOLD_CYCLES = 200;
	localparam int STUCK_LIMIT = 2000;
	localparam int END_PAUSE   = 20;

	typedef enum int {KEYS_FEW, KEYS_WIDE, KEYS_EXTREME, KEYS_HIGH} key_mix_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	int errors, pending, beats_checked, refusals, longest_drain;
	int sent_cmds = 0;
	int stuck_cycles = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #1 clk = ~clk;

	sorted_insert_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	siq_scoreboard u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.errors        (errors),
		.pending       (pending),
		.beats_checked (beats_checked),
		.refusals      (refusals),
		.longest_drain (longest_drain)
	);

	function automatic rec_t make_record(input logic [KEY_W-1:0] key,
			input logic [LEN_W-1:0] length, input logic [FID_W-1:0] file_id,
			input logic [FOFF_W-1:0] foff);
		rec_t r;
		r.key         = key;
		r.length      = length;
		r.file_id     = file_id;
		r.foff        = foff;
		return r;
	endfunction

	// random payload, key drawn from the chosen mix
	function automatic rec_t random_record(input key_mix_e mix);
		rec_t r;
		r.length      = LEN_W'($urandom);
		r.file_id     = FID_W'($urandom);
		r.foff        = FOFF_W'({$urandom, $urandom});
		case (mix)
			KEYS_FEW:     r.key = KEY_W'($urandom_range(0, 7));
			KEYS_WIDE:    r.key = KEY_W'({$urandom, $urandom});
			KEYS_EXTREME: r.key = $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
			default:      r.key = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
		endcase
		return r;
	endfunction

	// offer one command beat, with random gaps ahead of it
	task automatic push_command(input logic op, input rec_t r);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W - FOFF_LO - FOFF_W){1'b0}}, r.foff, r.file_id,
			r.length, r.key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_cmds++;
	endtask

	task automatic drain_store();
		push_command(OP_DRAIN, random_record(KEYS_WIDE));
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			m_tready <= !(idle_on && $urandom_range(0, 99) < 33);
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
			else stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
				$display("tb_sorted_insert_queue_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int rand_cmds;
		int burst;
		int pick;
		key_mix_e mix;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty drain, key and payload extremes, equal keys, single-entry drain
		drain_store();
		push_command(OP_INSERT, make_record('1, '1, '1, '1));
		push_command(OP_INSERT, make_record('0, '0, '0, '0));
		push_command(OP_INSERT, make_record(48'd5, 31'd1, 31'd1, 48'd1));
		push_command(OP_INSERT, make_record(48'd5, 31'd2, 31'd2, 48'd2));
		push_command(OP_INSERT, make_record(48'd5, 31'd3, 31'd3, 48'd3));
		push_command(OP_INSERT, make_record(48'h8000_0000_0000, 31'h4000_0000,
			31'h2aaa_aaaa, 48'h5555_5555_5555));
		push_command(OP_INSERT, make_record('1, 31'd7, 31'd7, 48'd7));
		drain_store();
		drain_store();
		push_command(OP_INSERT, make_record(48'd42, '1, '0, '1));
		drain_store();

		// pressure: receiver holds off while more inserts than the store holds are offered, then a drain
		hold_req = 1'b1;
		for (int i = 0; i < DEPTH + 4; i++) push_command(OP_INSERT, random_record(KEYS_FEW));
		drain_store();

		// random part: insert bursts mostly ending in drains, fills to near or past full, stray drains
		rand_cmds = 0;
		while (rand_cmds < RANDOM_CMDS) begin
			idle_on = !(rand_cmds >= 50 && rand_cmds < 100);
			pick = $urandom_range(0, 9);
			mix = key_mix_e'($urandom_range(0, 3));
			if (pick < 7) begin
				burst = $urandom_range(1, 10);
				for (int i = 0; i < burst; i++) push_command(OP_INSERT, random_record(mix));
				rand_cmds += burst;
				if ($urandom_range(0, 3) != 0) begin
					drain_store();
					rand_cmds++;
				end
			end else if (pick < 9) begin
				burst = $urandom_range(DEPTH - 8, DEPTH + 4);
				for (int i = 0; i < burst; i++) push_command(OP_INSERT, random_record(mix));
				drain_store();
				rand_cmds += burst + 1;
			end else begin
				drain_store();
				drain_store();
				rand_cmds += 2;
			end
		end
		idle_on = 1'b1;
		s_tvalid <= 1'b0;

		// let the last prediction land, then wait out the results
		@(posedge clk);
		wait (pending == 0);
		repeat (END_PAUSE) @(posedge clk);

		$display("sent %0d commands, checked %0d result beats", sent_cmds, beats_checked);
		$display("refused inserts %0d, longest drain %0d entries", refusals, longest_drain);
		if (errors == 0) begin
			$display("tb_sorted_insert_queue_top OK");
		end else begin
			$display("tb_sorted_insert_queue_top NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/siq_pkg.sv
hw/rtl/siq_front.sv
hw/rtl/siq_cmd_queue.sv
hw/rtl/siq_back.sv
hw/rtl/sorted_insert_queue_top.sv
hw/rtl/siq_checker.sv
verif/siq_checker.sv
verif/tb_sorted_insert_queue_top.sv
